### hdl/rqt_pkg.sv
// Shared types and constants for the read quality trimmer.
// No dependencies; every other file in hdl/ but rqt_ram imports this package.
package rqt_pkg;

  localparam int MAX_READ_LEN = 1024;
  localparam int ADDR_W       = $clog2(MAX_READ_LEN);
  localparam int CNT_W        = $clog2(MAX_READ_LEN + 1);
  localparam int POS_W        = 11;
  localparam int QUAL_W       = 7;
  localparam int BASE_W       = 8;
  localparam int SIZE_W       = 11;
  localparam int SCORE_W      = 18;
  localparam int QSUM_W       = 17;
  localparam int PROD_W       = QUAL_W + SIZE_W;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [QUAL_W-1:0] PHRED_OFFSET = QUAL_W'(33);
  localparam logic [BASE_W-1:0] UNKNOWN_BASE = BASE_W'(78);  // 'N'

  localparam logic [QUAL_W-1:0] MBQ_RESET = QUAL_W'(20);

  typedef struct packed {
    logic [QUAL_W-1:0] qual_char;
    logic [BASE_W-1:0] base_char;
    logic              last_of_read;
  } rqt_in_t;

  typedef struct packed {
    logic             discard;
    logic [POS_W-1:0] region_start;
    logic [POS_W-1:0] region_stop;
  } rqt_out_t;

  typedef struct packed {
    logic [QUAL_W-1:0] min_base_quality;
    logic [QUAL_W-1:0] mean_qual_floor;
    logic [SIZE_W-1:0] min_region_size;
  } rqt_cfg_t;

  typedef enum logic [1:0] {
    REG_MIN_BASE_Q  = 2'd0,
    REG_MIN_MEAN_Q  = 2'd1,
    REG_MIN_REGION  = 2'd2
  } rqt_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LREQ,
    ST_LCHK,
    ST_RREQ,
    ST_RCHK,
    ST_MUL,
    ST_DONE
  } rqt_state_t;

  typedef struct packed {
    logic accept;      // base transfer this cycle
    logic rd_left;     // flag read at left end
    logic rd_right;    // flag read at right end
    logic step_left;   // move left end inward
    logic step_right;  // move right end inward
    logic calc;        // span and mean threshold product
    logic load_out;    // verdict into output register, clear read state
  } rqt_cmd_t;

  typedef struct packed {
    logic left_go;
    logic right_go;
    logic flag;
    logic out_free;
  } rqt_sts_t;

endpackage

### hdl/rqt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rqt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/rqt_ctrl.sv
// Sequencer for the trimmer: base intake, N walk at both ends, verdict.
// Depends on rqt_pkg.
module rqt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  rqt_pkg::rqt_sts_t sts,
  output rqt_pkg::rqt_cmd_t cmd
);
  import rqt_pkg::*;

  rqt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_LREQ;
        end
      end
      ST_LREQ: begin
        if (sts.left_go) begin
          cmd.rd_left = 1'b1;
          state_nxt   = ST_LCHK;
        end else begin
          state_nxt = ST_RREQ;
        end
      end
      ST_LCHK: begin
        if (sts.flag) begin
          cmd.step_left = 1'b1;
          state_nxt     = ST_LREQ;
        end else begin
          state_nxt = ST_RREQ;
        end
      end
      ST_RREQ: begin
        if (sts.right_go) begin
          cmd.rd_right = 1'b1;
          state_nxt    = ST_RCHK;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_RCHK: begin
        if (sts.flag) begin
          cmd.step_right = 1'b1;
          state_nxt      = ST_RREQ;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/rqt_dp.sv
// Trimmer datapath: per-base scoring, N flag store, end walk, verdict, output register.
// Depends on rqt_pkg and rqt_ram.
module rqt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rqt_pkg::rqt_cfg_t cfg,
  input  rqt_pkg::rqt_in_t  in_data,
  input  rqt_pkg::rqt_cmd_t cmd,
  output rqt_pkg::rqt_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output rqt_pkg::rqt_out_t out_data
);
  import rqt_pkg::*;

  logic [CNT_W-1:0]   base_index_r;
  logic               start_found_r;
  logic [CNT_W-1:0]   left_pos_r;
  logic [CNT_W-1:0]   right_pos_r;
  logic [SCORE_W-1:0] run_score_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [QSUM_W-1:0]  qsum_run_r;
  logic [QSUM_W-1:0]  qsum_best_r;
  logic [SIZE_W-1:0]  span_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  rqt_out_t           out_data_r;

  logic [QUAL_W-1:0]  phred;
  logic [SCORE_W-1:0] raised;
  logic [SCORE_W-1:0] run_step;
  logic [QSUM_W-1:0]  qrun_step;
  logic               in_range;
  logic [SIZE_W-1:0]  span;
  logic               drop;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_flag;

  // Scoring of the incoming base
  always_comb begin
    phred     = (in_data.qual_char < PHRED_OFFSET) ? '0 : in_data.qual_char - PHRED_OFFSET;
    raised    = run_score_r + SCORE_W'(phred);
    run_step  = (raised < SCORE_W'(cfg.min_base_quality)) ? '0 :
                raised - SCORE_W'(cfg.min_base_quality);
    qrun_step = qsum_run_r + QSUM_W'(phred);
    in_range  = base_index_r < CNT_W'(MAX_READ_LEN);
  end

  // Flag store: written at intake, read during the end walk
  assign ram_we = cmd.accept && in_range;

  always_comb begin
    if (cmd.rd_right) begin
      ram_addr = right_pos_r[ADDR_W-1:0];
    end else if (cmd.rd_left) begin
      ram_addr = left_pos_r[ADDR_W-1:0];
    end else begin
      ram_addr = base_index_r[ADDR_W-1:0];
    end
  end

  rqt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_READ_LEN)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.base_char == UNKNOWN_BASE),
    .rdata (ram_flag)
  );

  assign span = SIZE_W'(right_pos_r - left_pos_r + CNT_W'(1));

  assign drop = !start_found_r || neg_r || (span_r < cfg.min_region_size) ||
                (PROD_W'(qsum_best_r) < prod_r);

  always_comb begin
    sts.left_go  = (left_pos_r != '0) && (left_pos_r < base_index_r);
    sts.right_go = (right_pos_r != '0) && (right_pos_r < base_index_r);
    sts.flag     = ram_flag;
    sts.out_free = !out_valid_r || out_ready;
  end

  // Read state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      base_index_r  <= '0;
      start_found_r <= 1'b0;
      left_pos_r    <= '0;
      right_pos_r   <= '0;
      run_score_r   <= '0;
      best_score_r  <= '0;
      qsum_run_r    <= '0;
      qsum_best_r   <= '0;
    end else begin
      if (ram_we) begin
        base_index_r <= base_index_r + CNT_W'(1);
        if (!start_found_r) begin
          if (phred >= cfg.min_base_quality) begin
            start_found_r <= 1'b1;
            left_pos_r    <= base_index_r;
            right_pos_r   <= base_index_r;
            run_score_r   <= SCORE_W'(phred - cfg.min_base_quality);
            best_score_r  <= SCORE_W'(phred - cfg.min_base_quality);
            qsum_run_r    <= QSUM_W'(phred);
            qsum_best_r   <= QSUM_W'(phred);
          end
        end else begin
          run_score_r <= run_step;
          qsum_run_r  <= qrun_step;
          if (best_score_r <= run_step) begin
            best_score_r <= run_step;
            right_pos_r  <= base_index_r;
            qsum_best_r  <= qrun_step;
          end
        end
      end
      if (cmd.step_left) begin
        left_pos_r <= left_pos_r + CNT_W'(1);
      end
      if (cmd.step_right) begin
        right_pos_r <= right_pos_r - CNT_W'(1);
      end
    end
  end

  // floor(sum / span) < mean  <=>  sum < mean * span
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      neg_r  <= right_pos_r < left_pos_r;
      span_r <= span;
      prod_r <= PROD_W'(cfg.mean_qual_floor) * PROD_W'(span);
    end
    if (cmd.load_out) begin
      out_data_r.discard      <= drop;
      out_data_r.region_start <= drop ? '0 : POS_W'(left_pos_r + CNT_W'(1));
      out_data_r.region_stop  <= drop ? '0 : POS_W'(right_pos_r + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_walk_left_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_left |-> left_pos_r < base_index_r)
    else $error("left walk reads beyond the stored bases");

  a_right_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    start_found_r |-> right_pos_r < base_index_r)
    else $error("right end outside the stored bases");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("verdict overwrites an untaken result");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (base_index_r == '0) && !start_found_r)
    else $error("read state not cleared after verdict");

endmodule

### hdl/read_quality_trimmer_core.sv
// Read quality trimmer: one base per cycle while a read streams in.
// After the last base: each end is walked inward over any 'N' bases (one flag
// store read per step), then the threshold product and the verdict are registered.
// The next read may stream in while the previous verdict waits to be taken.
// Reset (rst_n low, synchronous) restores default thresholds and clears read state;
// the N flag store is not cleared, each entry is written before it is read.
module read_quality_trimmer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // base channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rqt_pkg::rqt_in_t                    in_data,
  // verdict channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output rqt_pkg::rqt_out_t                   out_data,
  // APB register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rqt_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [rqt_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [rqt_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import rqt_pkg::*;

  rqt_cfg_t cfg_r;
  rqt_cmd_t cmd;
  rqt_sts_t sts;
  rqt_reg_t reg_sel;
  logic     cfg_wr;

  // Registers sit at byte addresses 0, 4 and 8; low address bits ignored
  assign reg_sel    = rqt_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_base_quality <= MBQ_RESET;
      cfg_r.mean_qual_floor  <= '0;
      cfg_r.min_region_size  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MIN_BASE_Q: cfg_r.min_base_quality <= cfg_pwdata[QUAL_W-1:0];
        REG_MIN_MEAN_Q: cfg_r.mean_qual_floor  <= cfg_pwdata[QUAL_W-1:0];
        REG_MIN_REGION: cfg_r.min_region_size  <= cfg_pwdata[SIZE_W-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_BASE_Q: cfg_prdata = PDATA_W'(cfg_r.min_base_quality);
      REG_MIN_MEAN_Q: cfg_prdata = PDATA_W'(cfg_r.mean_qual_floor);
      REG_MIN_REGION: cfg_prdata = PDATA_W'(cfg_r.min_region_size);
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer: intake, left walk, right walk, threshold product, verdict
  rqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_of_read),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Scoring, flag store and output register
  rqt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
